>>> rtl/nls_pkg.sv
// shared types, constants and falloff tables of the nearest light selector
package nls_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EYE_X  = 2'd0,
		REG_EYE_Y  = 2'd1,
		REG_EYE_Z  = 2'd2,
		REG_COMPAT = 2'd3
	} cfg_reg_t;

	// default sizes
	localparam int MAX_LIGHTS_DEF  = 32;
	localparam int POINT_SLOTS_DEF = 5;
	localparam int TOTAL_SLOTS_DEF = 7;

	// field widths
	localparam int COORD_W = 16;
	localparam int OUT_W   = 23;
	localparam int DIST_W  = 36;
	localparam int POS_W   = 3 * COORD_W;
	localparam int ATTR_W  = 33;

	// falloff encoding
	localparam int FallDenA   = 65025;
	localparam int FallScaleA = 128;
	localparam int FallDenB   = 255;
	localparam int FallTopB   = 255;
	localparam int FallFloor  = 10;
	localparam logic [7:0] FALL_A_MODE0 = 8'd1;
	localparam logic [7:0] FALL_B_MODE1 = 8'd128;
	localparam logic signed [OUT_W-1:0] POS_SCALE = 23'sd100;

	typedef logic [7:0] fall_tab_t [256];

	// half-scale falloff, indexed by radius
	function automatic fall_tab_t build_fall_a();
		fall_tab_t t;
		int c;
		int v;
		for (int r = 0; r < 256; r++) begin
			c = (FallScaleA * r * r + FallDenA - 1) / FallDenA;
			v = FallScaleA - c;
			if (v < FallFloor) v = FallFloor;
			t[r] = 8'(v);
		end
		return t;
	endfunction

	// normal falloff, indexed by radius
	function automatic fall_tab_t build_fall_b();
		fall_tab_t t;
		int c;
		int v;
		for (int r = 0; r < 256; r++) begin
			c = (r * r + FallDenB - 1) / FallDenB;
			v = FallTopB - c;
			if (v < FallFloor) v = FallFloor;
			t[r] = 8'(v);
		end
		return t;
	endfunction

	localparam fall_tab_t FALL_A_TAB = build_fall_a();
	localparam fall_tab_t FALL_B_TAB = build_fall_b();

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DIR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} state_t;

endpackage

>>> rtl/nls_in_if.sv
// input channel carrying one light per item
interface nls_in_if;
	logic               valid;
	logic               ready;
	logic               is_directional;
	logic signed [15:0] x;
	logic signed [15:0] y;
	logic signed [15:0] z;
	logic        [7:0]  radius;
	logic        [7:0]  red;
	logic        [7:0]  green;
	logic        [7:0]  blue;
	logic               batch_end;

	modport source (output valid, is_directional, x, y, z, radius, red, green, blue,
		batch_end, input ready);
	modport sink (input valid, is_directional, x, y, z, radius, red, green, blue,
		batch_end, output ready);
endinterface

>>> rtl/nls_out_if.sv
// output channel carrying one selected light entry per item
interface nls_out_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic               is_directional_res;
	logic signed [22:0] out_x;
	logic signed [22:0] out_y;
	logic signed [22:0] out_z;
	logic        [7:0]  out_red;
	logic        [7:0]  out_green;
	logic        [7:0]  out_blue;
	logic        [7:0]  falloff_a;
	logic        [7:0]  falloff_b;
	logic               run_end;

	modport source (output valid, valid_res, is_directional_res, out_x, out_y, out_z,
		out_red, out_green, out_blue, falloff_a, falloff_b, run_end, input ready);
	modport sink (input valid, valid_res, is_directional_res, out_x, out_y, out_z,
		out_red, out_green, out_blue, falloff_a, falloff_b, run_end, output ready);
endinterface

>>> rtl/nls_ram.sv
// generic single write port ram with registered read
module nls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/nls_dist.sv
// pipelined squared distance from a light position to the eye point
module nls_dist #(
	parameter int IDX_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld,
	input  logic [IDX_W-1:0]            idx,
	input  logic [nls_pkg::POS_W-1:0]   pos,
	input  logic signed [15:0]          eye_x,
	input  logic signed [15:0]          eye_y,
	input  logic signed [15:0]          eye_z,
	output logic                        dist_vld,
	output logic [IDX_W-1:0]            dist_idx,
	output logic [nls_pkg::DIST_W-1:0]  sq_dist,
	output logic                        busy
);
	import nls_pkg::*;

	logic signed [16:0] dx, dy, dz;
	logic [16:0] ax_s2, ay_s2, az_s2;
	logic [33:0] qx_s3, qy_s3, qz_s3;
	logic vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [DIST_W-1:0] sum_s4;

	// signed differences
	assign dx = 17'(signed'(pos[47:32])) - 17'(eye_x);
	assign dy = 17'(signed'(pos[31:16])) - 17'(eye_y);
	assign dz = 17'(signed'(pos[15:0]))  - 17'(eye_z);

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// magnitude, square, sum
	always_ff @(posedge clk) begin
		ax_s2  <= dx[16] ? 17'(-dx) : 17'(dx);
		ay_s2  <= dy[16] ? 17'(-dy) : 17'(dy);
		az_s2  <= dz[16] ? 17'(-dz) : 17'(dz);
		idx_s2 <= idx;
		qx_s3  <= ax_s2 * ax_s2;
		qy_s3  <= ay_s2 * ay_s2;
		qz_s3  <= az_s2 * az_s2;
		idx_s3 <= idx_s2;
		sum_s4 <= DIST_W'(qx_s3) + DIST_W'(qy_s3) + DIST_W'(qz_s3);
		idx_s4 <= idx_s3;
	end

	assign dist_vld = vld_s4;
	assign dist_idx = idx_s4;
	assign sq_dist  = sum_s4;
	assign busy     = vld_s2 | vld_s3 | vld_s4;

	// busy covers every stage in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld |=> busy) else $error("distance pipe lost an entry");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld && !busy) |=> !dist_vld) else $error("distance output without input");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld |-> ##3 dist_vld) else $error("distance latency broken");

endmodule

>>> rtl/nearest_light_selector_unit.sv
// top level: light store, nearest point light selection and list output
//
//  channel   dir  handshake      contents
//  lights    in   valid/ready    one light, batch_end closes the batch
//  entries   out  valid/ready    one list entry, run_end on the last
//  cfg       in   cfg_we         eye_x, eye_y, eye_z, compat_mode
//
// loading takes one light per cycle. after the batch_end light, each of up to
// POINT_SLOTS passes reads the store once through the ram and the distance pipe.
// the direction scan reads the store once more, then each entry is read through
// the ram read port and held until the output accepts it.
// reset clears the count, taken mask and sequencer; the stores stay undefined.
// lights are not taken from selection start until the last entry is accepted.
module nearest_light_selector_unit #(
	parameter int MAX_LIGHTS  = nls_pkg::MAX_LIGHTS_DEF,
	parameter int POINT_SLOTS = nls_pkg::POINT_SLOTS_DEF,
	parameter int TOTAL_SLOTS = nls_pkg::TOTAL_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nls_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [nls_pkg::CFG_DATA_W-1:0]  cfg_data,
	nls_in_if.sink                          lights,
	nls_out_if.source                       entries
);
	import nls_pkg::*;

	localparam int IDX_W  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
	localparam int SLOT_W = $clog2(POINT_SLOTS + 1);
	localparam int NW     = $clog2(TOTAL_SLOTS + 1);
	localparam int KW     = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

	state_t state_q, state_d;

	logic signed [15:0] eye_x_q, eye_y_q, eye_z_q;
	logic compat_q;

	logic [CNT_W-1:0]  count_q, iss_q;
	logic [SLOT_W-1:0] slot_q;
	logic [NW-1:0]     n_q;
	logic [KW-1:0]     k_q;
	logic [MAX_LIGHTS-1:0] taken_q;
	logic [IDX_W-1:0]  sel_q [TOTAL_SLOTS];
	logic              found_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  bidx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic [POS_W-1:0]  pos_rd;
	logic [ATTR_W-1:0] attr_rd;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;

	logic dist_vld, dist_busy;
	logic [IDX_W-1:0]  dist_idx;
	logic [DIST_W-1:0] sq_dist;

	logic in_acc, out_acc, issue, pass_done, dir_done, eligible, dir_hit, last_k;
	logic more_pass;

	// output register
	logic out_vld_q, o_valid_res_q, o_dir_q, o_run_end_q;
	logic signed [OUT_W-1:0] o_x_q, o_y_q, o_z_q;
	logic [7:0] o_r_q, o_g_q, o_b_q, o_fa_q, o_fb_q;

	// attribute fields of the read entry
	logic       a_dir;
	logic [7:0] a_rad;
	logic signed [15:0] p_x, p_y, p_z;
	assign a_dir = attr_rd[32];
	assign a_rad = attr_rd[31:24];
	assign p_x   = pos_rd[47:32];
	assign p_y   = pos_rd[31:16];
	assign p_z   = pos_rd[15:0];

	// handshake and sequencing strobes
	assign lights.ready = (state_q == ST_LOAD);
	assign in_acc    = lights.valid && lights.ready;
	assign out_acc   = out_vld_q && entries.ready;
	assign wr_en     = in_acc && (count_q < CNT_W'(MAX_LIGHTS));
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_DIR)) && (iss_q < count_q);
	assign rd_addr   = (state_q == ST_EMIT_RD) ? sel_q[k_q] : iss_q[IDX_W-1:0];
	assign pass_done = (state_q == ST_SCAN) && !issue && !rd_vld_s1 && !dist_busy;
	assign dir_done  = (state_q == ST_DIR) && !issue && !rd_vld_s1;
	assign eligible  = rd_vld_s1 && (state_q == ST_SCAN) && !a_dir && (a_rad != 8'd0)
		&& !taken_q[rd_idx_s1];
	assign dir_hit   = rd_vld_s1 && (state_q == ST_DIR) && a_dir && (n_q < NW'(TOTAL_SLOTS));
	assign last_k    = ({1'b0, k_q} + 1 == n_q);
	assign more_pass = found_q && (slot_q + 1 < POINT_SLOTS) && (n_q + 1 < TOTAL_SLOTS);

	// position and attribute stores
	nls_ram #(.WIDTH(POS_W), .DEPTH(MAX_LIGHTS), .AW(IDX_W)) u_pos_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({lights.x, lights.y, lights.z}),
		.raddr (rd_addr),
		.rdata (pos_rd)
	);

	nls_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_LIGHTS), .AW(IDX_W)) u_attr_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({lights.is_directional, lights.radius, lights.red, lights.green,
			lights.blue}),
		.raddr (rd_addr),
		.rdata (attr_rd)
	);

	// distance pipe
	nls_dist #(.IDX_W(IDX_W)) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (eligible),
		.idx      (rd_idx_s1),
		.pos      (pos_rd),
		.eye_x    (eye_x_q),
		.eye_y    (eye_y_q),
		.eye_z    (eye_z_q),
		.dist_vld (dist_vld),
		.dist_idx (dist_idx),
		.sq_dist  (sq_dist),
		.busy     (dist_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q  <= '0;
			eye_y_q  <= '0;
			eye_z_q  <= '0;
			compat_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_EYE_X:  eye_x_q  <= cfg_data;
				REG_EYE_Y:  eye_y_q  <= cfg_data;
				REG_EYE_Z:  eye_z_q  <= cfg_data;
				REG_COMPAT: compat_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && lights.batch_end) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (pass_done && !more_pass) state_d = ST_DIR;
			end
			ST_DIR: begin
				if (dir_done) state_d = (n_q == '0) ? ST_EMIT_OUT : ST_EMIT_RD;
			end
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_acc) state_d = o_run_end_q ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control counters and selection bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			iss_q     <= '0;
			slot_q    <= '0;
			n_q       <= '0;
			k_q       <= '0;
			taken_q   <= '0;
			found_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) iss_q <= iss_q + 1'b1;
			if (wr_en) count_q <= count_q + 1'b1;
			if (in_acc && lights.batch_end) begin
				iss_q   <= '0;
				slot_q  <= '0;
				n_q     <= '0;
				found_q <= 1'b0;
			end
			// running minimum, earliest wins on a tie
			if (dist_vld && (!found_q || sq_dist < best_q)) found_q <= 1'b1;
			// close a pass
			if (pass_done) begin
				iss_q   <= '0;
				found_q <= 1'b0;
				if (found_q) begin
					taken_q[bidx_q] <= 1'b1;
					n_q    <= n_q + 1'b1;
					slot_q <= slot_q + 1'b1;
				end
			end
			if (dir_hit) n_q <= n_q + 1'b1;
			if (dir_done) k_q <= '0;
			// output valid
			if (state_q == ST_EMIT_LD || (dir_done && n_q == '0)) out_vld_q <= 1'b1;
			else if (out_acc) out_vld_q <= 1'b0;
			if (out_acc) begin
				k_q <= k_q + 1'b1;
				if (o_run_end_q) begin
					count_q <= '0;
					taken_q <= '0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= iss_q[IDX_W-1:0];
		if (dist_vld && (!found_q || sq_dist < best_q)) begin
			best_q <= sq_dist;
			bidx_q <= dist_idx;
		end
		if (pass_done && found_q) sel_q[n_q[KW-1:0]] <= bidx_q;
		if (dir_hit) sel_q[n_q[KW-1:0]] <= rd_idx_s1;
		// lone marker when nothing was selected
		if (dir_done && n_q == '0) begin
			o_valid_res_q <= 1'b0;
			o_dir_q       <= 1'b0;
			o_x_q         <= '0;
			o_y_q         <= '0;
			o_z_q         <= '0;
			o_r_q         <= '0;
			o_g_q         <= '0;
			o_b_q         <= '0;
			o_fa_q        <= '0;
			o_fb_q        <= '0;
			o_run_end_q   <= 1'b1;
		end
		// format the entry read from the store
		if (state_q == ST_EMIT_LD) begin
			o_valid_res_q <= 1'b1;
			o_dir_q       <= a_dir;
			o_r_q         <= attr_rd[23:16];
			o_g_q         <= attr_rd[15:8];
			o_b_q         <= attr_rd[7:0];
			o_run_end_q   <= last_k;
			if (a_dir) begin
				o_x_q  <= OUT_W'(p_x);
				o_y_q  <= OUT_W'(p_y);
				o_z_q  <= OUT_W'(p_z);
				o_fa_q <= 8'd0;
				o_fb_q <= 8'd0;
			end else begin
				o_x_q  <= OUT_W'(p_x) * POS_SCALE;
				o_y_q  <= OUT_W'(p_y) * POS_SCALE;
				o_z_q  <= OUT_W'(p_z) * POS_SCALE;
				o_fa_q <= compat_q ? FALL_A_TAB[a_rad] : FALL_A_MODE0;
				o_fb_q <= compat_q ? FALL_B_MODE1 : FALL_B_TAB[a_rad];
			end
		end
	end

	assign entries.valid              = out_vld_q;
	assign entries.valid_res          = o_valid_res_q;
	assign entries.is_directional_res = o_dir_q;
	assign entries.out_x              = o_x_q;
	assign entries.out_y              = o_y_q;
	assign entries.out_z              = o_z_q;
	assign entries.out_red            = o_r_q;
	assign entries.out_green          = o_g_q;
	assign entries.out_blue           = o_b_q;
	assign entries.falloff_a          = o_fa_q;
	assign entries.falloff_b          = o_fb_q;
	assign entries.run_end            = o_run_end_q;

	// checks
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		entries.valid |-> state_q == ST_EMIT_OUT) else $error("item shown outside output state");
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(TOTAL_SLOTS)) else $error("selected list overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LIGHTS)) else $error("light count overflow");
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_q) <= POINT_SLOTS) else $error("too many lights taken");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(entries.valid && entries.ready && entries.run_end) |=> (count_q == '0 && taken_q == '0))
		else $error("batch not cleared after last item");

endmodule
